// File: hdl/fpd_pkg.sv
package fpd_pkg;

  localparam int LANE_W = 8;
  localparam int LANES  = 4;
  localparam int PIX_W  = LANE_W * LANES;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [7:0]       coord_t;

  // column phase of the first and the last pixel in a group of four
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_LAST  = 2'd3;

  // row phase within a block of four source rows
  localparam logic [1:0] ROW_FIRST  = 2'd0;
  localparam logic [1:0] ROW_SECOND = 2'd1;
  localparam logic [1:0] ROW_THIRD  = 2'd2;
  localparam logic [1:0] ROW_FOURTH = 2'd3;

  // per lane floor((3p + q) / 4)
  function automatic pix_t blend_31(pix_t p, pix_t q);
    logic [LANE_W+1:0] s;
    pix_t r;
    for (int i = 0; i < LANES; i++) begin
      s = ({2'b00, p[LANE_W*i +: LANE_W]} << 1) + {2'b00, p[LANE_W*i +: LANE_W]}
          + {2'b00, q[LANE_W*i +: LANE_W]};
      r[LANE_W*i +: LANE_W] = s[LANE_W+1:2];
    end
    return r;
  endfunction

  // per lane floor((p + q) / 2)
  function automatic pix_t blend_22(pix_t p, pix_t q);
    logic [LANE_W:0] s;
    pix_t r;
    for (int i = 0; i < LANES; i++) begin
      s = {1'b0, p[LANE_W*i +: LANE_W]} + {1'b0, q[LANE_W*i +: LANE_W]};
      r[LANE_W*i +: LANE_W] = s[LANE_W:1];
    end
    return r;
  endfunction

  // per lane floor((p + 3q) / 4)
  function automatic pix_t blend_13(pix_t p, pix_t q);
    return blend_31(q, p);
  endfunction

endpackage

// File: hdl/fpd_ram.sv
module fpd_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 80,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/four_to_three_pixel_downscaler.sv
// Four-to-three pixel downscaler.
// Input channel (in_valid/in_ready): one request per source pixel, raster
// order, SRC_WIDTH x SRC_HEIGHT per frame; frame_start marks column 0, row 0.
// Output channel (out_valid/out_ready): downscaled pixels with their
// destination column and row; run_last flags the third pixel of a group.
// Configuration: cfg_wr_en writes scale_mode (0 stretch, 1 scale) at once.
// Each group of four source pixels yields three results (none on the first
// row of a four-row block in scale mode). The three results come out in
// order, one per accepted output; after the fourth pixel of a group is
// taken, they pass through the staging register into the result buffer.
// Throughput: one pixel per cycle when not stalled. The line store is one
// 1-read/1-write RAM row per group (three reduced pixels wide): the row is
// read when the first pixel of a group arrives and written with the fourth,
// so one RAM access per group each way sets no limit below that.
// When the receiver stalls, the result buffer and one staging register
// fill, and in_ready drops only for a fourth-of-group pixel.
// Reset: counters to zero, scale_mode to 1, pending results dropped. The
// line store is not cleared; every row it serves was written by the row
// before it.
module four_to_three_pixel_downscaler
  import fpd_pkg::*;
#(
  parameter int SRC_WIDTH     = 320,
  parameter int SRC_HEIGHT    = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_wr_en,
  input  logic   cfg_wr_data,
  input  logic   in_valid,
  output logic   in_ready,
  input  pix_t   src_pixel,
  input  logic   frame_start,
  output logic   out_valid,
  input  logic   out_ready,
  output pix_t   out_pixel,
  output coord_t dest_x,
  output coord_t dest_y,
  output logic   run_last
);

  localparam int CW          = $clog2(SRC_WIDTH);
  localparam int RW          = $clog2(SRC_HEIGHT);
  localparam int NGROUPS     = SRC_WIDTH / 4;
  localparam int AW          = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int SCALED_ROWS = (SRC_HEIGHT / 4) * 3;
  localparam int V_OFFSET    = (SCREEN_HEIGHT > SCALED_ROWS) ?
                               (SCREEN_HEIGHT - SCALED_ROWS) / 2 : 0;
  localparam coord_t VOFF    = coord_t'(V_OFFSET);

  // configuration
  logic scale_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      scale_mode <= cfg_wr_data;
    end
  end

  // position counters
  logic [CW-1:0] column_count, column_next;
  logic [RW-1:0] row_count, row_next;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [1:0]    phase;
  logic [1:0]    row_phase;
  logic [CW-1:0] group_idx;
  logic          in_fire;

  // frame_start restarts the counters at this pixel
  assign col_eff   = frame_start ? '0 : column_count;
  assign row_eff   = frame_start ? '0 : row_count;
  assign phase     = col_eff[1:0];
  assign row_phase = row_eff[1:0];
  assign group_idx = col_eff >> 2;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    col_inc     = {1'b0, col_eff} + 1'b1;
    row_inc     = {1'b0, row_eff} + 1'b1;
    column_next = col_inc[CW-1:0];
    row_next    = row_eff;
    if (col_inc == (CW+1)'(SRC_WIDTH)) begin
      column_next = '0;
      row_next    = (row_inc == (RW+1)'(SRC_HEIGHT)) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  // first three pixels of the group
  pix_t group_pixels [3];

  always_ff @(posedge clk) begin
    if (in_fire && phase != PHASE_LAST) begin
      group_pixels[phase] <= src_pixel;
    end
  end

  // horizontal reduction, done as the fourth pixel arrives
  pix_t red [3];

  assign red[0] = blend_31(group_pixels[0], group_pixels[1]);
  assign red[1] = blend_22(group_pixels[1], group_pixels[2]);
  assign red[2] = blend_13(group_pixels[2], src_pixel);

  // line store: one row per group, three reduced pixels wide.
  // Read on the group's first pixel, write back on its fourth.
  logic            ls_re, ls_we;
  logic [AW-1:0]   ls_addr;
  logic [3*PIX_W-1:0] ls_rdata;

  assign ls_addr = AW'(group_idx);
  assign ls_re   = in_fire && phase == PHASE_FIRST && group_idx < CW'(NGROUPS);
  assign ls_we   = in_fire && phase == PHASE_LAST;

  fpd_ram #(
    .WIDTH (3*PIX_W),
    .DEPTH (NGROUPS)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_addr),
    .wdata ({red[2], red[1], red[0]}),
    .re    (ls_re),
    .raddr (ls_addr),
    .rdata (ls_rdata)
  );

  // staging register: one group awaiting the result buffer
  logic   s1_valid;
  pix_t   s1_red [3];
  pix_t   s1_prev [3];
  logic   s1_scale;
  logic [1:0] s1_rp;
  coord_t s1_base;
  coord_t s1_dy;
  coord_t grp8, base8, row8, dy_scale;
  logic   emit;
  logic   s1_move;
  logic   buf_free;

  assign grp8     = coord_t'(group_idx);
  assign base8    = {grp8[6:0], 1'b0} + grp8;
  assign row8     = coord_t'(row_eff >> 2);
  assign dy_scale = {row8[6:0], 1'b0} + row8 + coord_t'(row_phase - 2'd1) + VOFF;
  // scale mode drops the first row of each block
  assign emit     = !scale_mode || row_phase != ROW_FIRST;

  // stall only a group's fourth pixel, and only while staging is full
  assign in_ready = column_count[1:0] != PHASE_LAST || !s1_valid;
  assign s1_move  = s1_valid && buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire && phase == PHASE_LAST && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase == PHASE_LAST) begin
      s1_red     <= red;
      s1_prev[0] <= ls_rdata[0*PIX_W +: PIX_W];
      s1_prev[1] <= ls_rdata[1*PIX_W +: PIX_W];
      s1_prev[2] <= ls_rdata[2*PIX_W +: PIX_W];
      s1_scale   <= scale_mode;
      s1_rp      <= row_phase;
      s1_base    <= base8;
      s1_dy      <= scale_mode ? dy_scale : coord_t'(row_eff);
    end
  end

  // vertical blend against the previous reduced row
  pix_t fin [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (s1_rp)
        ROW_SECOND: fin[k] = blend_31(s1_prev[k], s1_red[k]);
        ROW_THIRD:  fin[k] = blend_22(s1_prev[k], s1_red[k]);
        ROW_FOURTH: fin[k] = blend_13(s1_prev[k], s1_red[k]);
        default:    fin[k] = s1_red[k];
      endcase
      if (!s1_scale) begin
        fin[k] = s1_red[k];
      end
    end
  end

  // result buffer: three pixels handed out one request at a time
  logic       buf_busy;
  logic [1:0] buf_k;
  pix_t       buf_val [3];
  coord_t     buf_base;
  coord_t     buf_dy;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;
  assign buf_free = !buf_busy || (out_ready && buf_k == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_busy <= 1'b0;
      buf_k    <= 2'd0;
    end else if (s1_move) begin
      buf_busy <= 1'b1;
      buf_k    <= 2'd0;
    end else if (out_fire) begin
      if (buf_k == 2'd2) begin
        buf_busy <= 1'b0;
      end else begin
        buf_k <= buf_k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      buf_val  <= fin;
      buf_base <= s1_base;
      buf_dy   <= s1_dy;
    end
  end

  assign out_valid = buf_busy;
  assign out_pixel = (buf_k == 2'd2) ? buf_val[2] :
                     (buf_k == 2'd1) ? buf_val[1] : buf_val[0];
  assign dest_x    = buf_base + coord_t'(buf_k);
  assign dest_y    = buf_dy;
  assign run_last  = buf_k == 2'd2;

endmodule

// File: hdl/fpd_checker.sv
module fpd_checker
  import fpd_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input pix_t   out_pixel,
  input coord_t dest_x,
  input coord_t dest_y,
  input logic   run_last
);

  // reset drops any pending results
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel)
      && $stable(dest_x) && $stable(dest_y) && $stable(run_last))
    else $error("stalled result changed");

  // the three results of a group follow in order, same row
  a_group_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid
      && dest_x == $past(dest_x) + 8'd1 && dest_y == $past(dest_y))
    else $error("group of three broken");

  // input stalls only while results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind four_to_three_pixel_downscaler fpd_checker u_fpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pixel (out_pixel),
  .dest_x    (dest_x),
  .dest_y    (dest_y),
  .run_last  (run_last)
);
